FILE: hw/rtl/ptpb_pkg.sv
// shared widths and register codes for the pixel to plane back-projection unit
// no dependencies
package ptpb_pkg;

  localparam int unsigned PIX_W   = 16;
  localparam int unsigned COEF_W  = 32;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned ELEM_W  = 49;
  localparam int unsigned MAG_W   = 48;
  localparam int unsigned HALF_W  = 24;
  localparam int unsigned PRD_W   = 96;
  localparam int unsigned SUM_W   = 98;
  localparam int unsigned DEN_W   = 97;
  localparam int unsigned FRAC_SH = 16;
  localparam int unsigned NUM_W   = DEN_W + FRAC_SH;
  localparam int unsigned QBITS   = 33;
  localparam int unsigned QUO_W   = QBITS + 1;
  localparam int unsigned DIV_LAT = QBITS + 2;
  localparam int unsigned NPROD   = 6;

  typedef enum logic [IDX_W-1:0] {
    CFG_ROW0   = 3'd0,
    CFG_ROW1   = 3'd1,
    CFG_ROW2   = 3'd2,
    CFG_OFF01  = 3'd3,
    CFG_OFF2   = 3'd4
  } cfg_idx_e;

endpackage

FILE: hw/rtl/ptpb_div.sv
// pipelined restoring divider, one quotient bit per stage, round to nearest
// depends on ptpb_pkg
module ptpb_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [ptpb_pkg::NUM_W-1:0]     num_i,
  input  logic [ptpb_pkg::DEN_W-1:0]     den_i,
  output logic [ptpb_pkg::QUO_W-1:0]     quo_o,
  output logic                           sat_o
);

  localparam int unsigned QB = ptpb_pkg::QBITS;
  localparam int unsigned DW = ptpb_pkg::DEN_W;
  localparam int unsigned NW = ptpb_pkg::NUM_W;

  logic [DW-1:0] r_q   [0:QB];
  logic [DW-1:0] d_q   [0:QB];
  logic [QB-1:0] nl_q  [0:QB];
  logic [QB-1:0] q_q   [0:QB];
  logic          sat_q [0:QB];

  logic [DW:0]   trial [1:QB];
  logic [DW:0]   diff  [1:QB];
  logic          take  [1:QB];

  logic [ptpb_pkg::QUO_W-1:0] quo_q;
  logic                       sat_out_q;
  logic [DW:0]                rem2;
  logic                       rnd;

  always_comb begin
    for (int s = 1; s <= QB; s++) begin
      trial[s] = {r_q[s-1], nl_q[s-1][QB-1]};
      diff[s]  = trial[s] - {1'b0, d_q[s-1]};
      take[s]  = trial[s] >= {1'b0, d_q[s-1]};
    end
    rem2 = {r_q[QB], 1'b0};
    rnd  = rem2 >= {1'b0, d_q[QB]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q[0] <= {{(DW+QB-NW){1'b0}}, num_i} >= {den_i, {QB{1'b0}}};
      r_q[0]   <= {{(DW-(NW-QB)){1'b0}}, num_i[NW-1:QB]};
      nl_q[0]  <= num_i[QB-1:0];
      d_q[0]   <= den_i;
      q_q[0]   <= '0;
      for (int s = 1; s <= QB; s++) begin
        r_q[s]   <= take[s] ? diff[s][DW-1:0] : trial[s][DW-1:0];
        nl_q[s]  <= {nl_q[s-1][QB-2:0], 1'b0};
        q_q[s]   <= {q_q[s-1][QB-2:0], take[s]};
        d_q[s]   <= d_q[s-1];
        sat_q[s] <= sat_q[s-1];
      end
      quo_q     <= {1'b0, q_q[QB]} + {{(ptpb_pkg::QUO_W-1){1'b0}}, rnd};
      sat_out_q <= sat_q[QB];
    end
  end

  assign quo_o = quo_q;
  assign sat_o = sat_out_q;

endmodule

FILE: hw/rtl/pixel_to_plane_backprojection_unit.sv
// Maps a pixel (u,v) onto the world plane Z=0 through a loaded projection matrix.
// One word enters per clock while the output is not blocked; each result passes
// through seven arithmetic stages, a 35-stage divider pipeline with one quotient
// bit per stage, and the output register. The whole pipeline stalls only while a
// result waits at the output. Depends on ptpb_pkg and ptpb_div.
module pixel_to_plane_backprojection_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // pixel_u [15:0], pixel_v [31:16]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // world_x [31:0], world_y [63:32]
  output logic        m_axis_tuser_o    // singular
);

  localparam int unsigned EW = ptpb_pkg::ELEM_W;
  localparam int unsigned MW = ptpb_pkg::MAG_W;
  localparam int unsigned HW = ptpb_pkg::HALF_W;
  localparam int unsigned PW = ptpb_pkg::PRD_W;
  localparam int unsigned SW = ptpb_pkg::SUM_W;
  localparam int unsigned DW = ptpb_pkg::DEN_W;
  localparam int unsigned NP = ptpb_pkg::NPROD;
  localparam int unsigned DL = ptpb_pkg::DIV_LAT;

  function automatic logic signed [EW-1:0] sx(input logic [31:0] c);
    sx = EW'($signed(c));
  endfunction

  logic [63:0] row0_q, row1_q, row2_q, off01_q;
  logic [31:0] off2_q;

  logic en;
  logic out_valid_q;
  logic [63:0] out_data_q;
  logic out_sing_q;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic [15:0] u1_q, vv1_q;

  logic signed [EW-1:0] a00_q, a01_q, a10_q, a11_q, um_q, vm_q;
  logic signed [EW-1:0] a00_d, a01_d, a10_d, a11_d, um_d, vm_d;
  logic signed [EW-1:0] uu, vv;

  logic signed [EW-1:0] opa [0:NP-1];
  logic signed [EW-1:0] opb [0:NP-1];
  logic [MW-1:0] ma_q [0:NP-1];
  logic [MW-1:0] mb_q [0:NP-1];
  logic          sg3_q [0:NP-1];

  logic [MW-1:0] pp_hh_q [0:NP-1];
  logic [MW-1:0] pp_hl_q [0:NP-1];
  logic [MW-1:0] pp_lh_q [0:NP-1];
  logic [MW-1:0] pp_ll_q [0:NP-1];
  logic          sg4_q [0:NP-1];

  logic [PW-1:0] pm_q [0:NP-1];
  logic          sg5_q [0:NP-1];
  logic signed [SW-1:0] ps [0:NP-1];

  logic signed [SW-1:0] det_q, nx_q, ny_q;

  logic [DW-1:0] dmag_q, nxmag_q, nymag_q;
  logic          negx7_q, negy7_q, sing7_q;

  logic dv_q [0:DL-1];
  logic dnx_q [0:DL-1];
  logic dny_q [0:DL-1];
  logic dsg_q [0:DL-1];

  logic [ptpb_pkg::QUO_W-1:0] qx, qy;
  logic satx, saty;
  logic [31:0] wx, wy;

  assign en = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q  <= '0;
      row1_q  <= '0;
      row2_q  <= '0;
      off01_q <= '0;
      off2_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptpb_pkg::CFG_ROW0:  row0_q  <= cfg_data_i;
        ptpb_pkg::CFG_ROW1:  row1_q  <= cfg_data_i;
        ptpb_pkg::CFG_ROW2:  row2_q  <= cfg_data_i;
        ptpb_pkg::CFG_OFF01: off01_q <= cfg_data_i;
        ptpb_pkg::CFG_OFF2:  off2_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // matrix elements at scale 2^16
  always_comb begin
    uu    = $signed({{(EW-16){1'b0}}, u1_q});
    vv    = $signed({{(EW-16){1'b0}}, vv1_q});
    a00_d = sx(row2_q[63:32]) * uu - (sx(row0_q[63:32]) <<< 4);
    a01_d = sx(row2_q[31:0])  * uu - (sx(row0_q[31:0])  <<< 4);
    a10_d = sx(row2_q[63:32]) * vv - (sx(row1_q[63:32]) <<< 4);
    a11_d = sx(row2_q[31:0])  * vv - (sx(row1_q[31:0])  <<< 4);
    um_d  = (sx(off01_q[63:32]) <<< 4) - sx(off2_q) * uu;
    vm_d  = (sx(off01_q[31:0])  <<< 4) - sx(off2_q) * vv;
  end

  // product pairs: det = p0 - p1, x num = p2 - p3, y num = p4 - p5
  always_comb begin
    opa[0] = a00_q; opb[0] = a11_q;
    opa[1] = a01_q; opb[1] = a10_q;
    opa[2] = um_q;  opb[2] = a11_q;
    opa[3] = vm_q;  opb[3] = a01_q;
    opa[4] = vm_q;  opb[4] = a00_q;
    opa[5] = um_q;  opb[5] = a10_q;
    for (int k = 0; k < NP; k++) begin
      ps[k] = sg5_q[k] ? -$signed({2'b00, pm_q[k]}) : $signed({2'b00, pm_q[k]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_q  <= s_axis_tdata_i[15:0];
      vv1_q <= s_axis_tdata_i[31:16];
      a00_q <= a00_d;
      a01_q <= a01_d;
      a10_q <= a10_d;
      a11_q <= a11_d;
      um_q  <= um_d;
      vm_q  <= vm_d;
      for (int k = 0; k < NP; k++) begin
        ma_q[k]    <= opa[k][EW-1] ? MW'(-opa[k]) : MW'(opa[k]);
        mb_q[k]    <= opb[k][EW-1] ? MW'(-opb[k]) : MW'(opb[k]);
        sg3_q[k]   <= opa[k][EW-1] ^ opb[k][EW-1];
        pp_hh_q[k] <= ma_q[k][MW-1:HW] * mb_q[k][MW-1:HW];
        pp_hl_q[k] <= ma_q[k][MW-1:HW] * mb_q[k][HW-1:0];
        pp_lh_q[k] <= ma_q[k][HW-1:0]  * mb_q[k][MW-1:HW];
        pp_ll_q[k] <= ma_q[k][HW-1:0]  * mb_q[k][HW-1:0];
        sg4_q[k]   <= sg3_q[k];
        pm_q[k]    <= {pp_hh_q[k], {MW{1'b0}}}
                    + {{HW{1'b0}}, pp_hl_q[k], {HW{1'b0}}}
                    + {{HW{1'b0}}, pp_lh_q[k], {HW{1'b0}}}
                    + {{MW{1'b0}}, pp_ll_q[k]};
        sg5_q[k]   <= sg4_q[k];
      end
      det_q   <= ps[0] - ps[1];
      nx_q    <= ps[2] - ps[3];
      ny_q    <= ps[4] - ps[5];
      dmag_q  <= det_q[SW-1] ? DW'(-det_q) : DW'(det_q);
      nxmag_q <= nx_q[SW-1]  ? DW'(-nx_q)  : DW'(nx_q);
      nymag_q <= ny_q[SW-1]  ? DW'(-ny_q)  : DW'(ny_q);
      negx7_q <= nx_q[SW-1] ^ det_q[SW-1];
      negy7_q <= ny_q[SW-1] ^ det_q[SW-1];
      sing7_q <= det_q == '0;
      dnx_q[0] <= negx7_q;
      dny_q[0] <= negy7_q;
      dsg_q[0] <= sing7_q;
      for (int k = 1; k < DL; k++) begin
        dnx_q[k] <= dnx_q[k-1];
        dny_q[k] <= dny_q[k-1];
        dsg_q[k] <= dsg_q[k-1];
      end
    end
    if (en) begin
      out_data_q <= {wy, wx};
      out_sing_q <= dsg_q[DL-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0;
      for (int k = 0; k < DL; k++) dv_q[k] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q;
      dv_q[0] <= v7_q;
      for (int k = 1; k < DL; k++) dv_q[k] <= dv_q[k-1];
      out_valid_q <= dv_q[DL-1];
    end
  end

  ptpb_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({nxmag_q, {ptpb_pkg::FRAC_SH{1'b0}}}),
    .den_i (dmag_q),
    .quo_o (qx),
    .sat_o (satx)
  );

  ptpb_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({nymag_q, {ptpb_pkg::FRAC_SH{1'b0}}}),
    .den_i (dmag_q),
    .quo_o (qy),
    .sat_o (saty)
  );

  // sign, saturation and singular override
  always_comb begin
    if (dsg_q[DL-1]) begin
      wx = '0;
    end else if (dnx_q[DL-1]) begin
      wx = (satx || qx > ptpb_pkg::QUO_W'(34'h080000000)) ? 32'h8000_0000 : 32'(-qx);
    end else begin
      wx = (satx || qx > ptpb_pkg::QUO_W'(34'h07FFFFFFF)) ? 32'h7FFF_FFFF : qx[31:0];
    end
    if (dsg_q[DL-1]) begin
      wy = '0;
    end else if (dny_q[DL-1]) begin
      wy = (saty || qy > ptpb_pkg::QUO_W'(34'h080000000)) ? 32'h8000_0000 : 32'(-qy);
    end else begin
      wy = (saty || qy > ptpb_pkg::QUO_W'(34'h07FFFFFFF)) ? 32'h7FFF_FFFF : qy[31:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_sing_q;

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("singular word with nonzero data");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v7_q) && $stable(dv_q[DL-1]))
    else $error("pipeline moved during stall");

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while output blocked");

endmodule
